/* hw/rtl/hsc_pkg.sv */
// hsc_pkg: shared types, jamo tables and lookup functions of the syllable composer
package hsc_pkg;

  localparam int ONSET_COUNT = 19;
  localparam int CODA_COUNT  = 28;
  localparam int VPAIR_COUNT = 7;
  localparam int CPAIR_COUNT = 11;

  localparam logic [15:0] BASE_CODE    = 16'hAC00;
  localparam logic [15:0] VOWEL_MUL    = 16'd21;
  localparam logic [15:0] CODA_MUL     = 16'd28;
  localparam logic [4:0]  SILENT_ONSET = 5'd11;
  localparam logic [15:0] VOWEL_FIRST  = 16'h314F;
  localparam logic [15:0] VOWEL_LAST   = 16'h3163;

  localparam logic [15:0] VOWEL_O  = 16'h3157;
  localparam logic [15:0] VOWEL_WA = 16'h3158;
  localparam logic [15:0] VOWEL_A  = 16'h314F;
  localparam logic [15:0] VOWEL_E  = 16'h3154;

  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_UNDO  = 2'd2;

  localparam logic [1:0] REG_WO = 2'd0;
  localparam logic [1:0] REG_WA = 2'd1;
  localparam logic [1:0] REG_E  = 2'd2;

  localparam logic [15:0] ONSET_TAB [ONSET_COUNT] = '{
    16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
    16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
    16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
  };

  localparam logic [15:0] CODA_TAB [CODA_COUNT] = '{
    16'h0000, 16'h3131, 16'h3132, 16'h3133, 16'h3134, 16'h3135, 16'h3136,
    16'h3137, 16'h3139, 16'h313A, 16'h313B, 16'h313C, 16'h313D, 16'h313E,
    16'h313F, 16'h3140, 16'h3141, 16'h3142, 16'h3144, 16'h3145, 16'h3146,
    16'h3147, 16'h3148, 16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
  };

  localparam logic [15:0] VP_A [VPAIR_COUNT] = '{
    16'h3157, 16'h3157, 16'h3157, 16'h315C, 16'h315C, 16'h315C, 16'h3161
  };
  localparam logic [15:0] VP_B [VPAIR_COUNT] = '{
    16'h314F, 16'h3150, 16'h3163, 16'h3153, 16'h3154, 16'h3163, 16'h3163
  };
  localparam logic [15:0] VP_RES [VPAIR_COUNT] = '{
    16'h3158, 16'h3159, 16'h315A, 16'h315D, 16'h315E, 16'h315F, 16'h3162
  };

  localparam logic [15:0] CP_A [CPAIR_COUNT] = '{
    16'h3131, 16'h3134, 16'h3134, 16'h3139, 16'h3139, 16'h3139, 16'h3139,
    16'h3139, 16'h3139, 16'h3139, 16'h3142
  };
  localparam logic [15:0] CP_B [CPAIR_COUNT] = '{
    16'h3145, 16'h3148, 16'h314E, 16'h3131, 16'h3141, 16'h3142, 16'h3145,
    16'h314C, 16'h314D, 16'h314E, 16'h3145
  };
  localparam logic [4:0] CP_RES [CPAIR_COUNT] = '{
    5'd3, 5'd5, 5'd6, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd18
  };
  // first part as coda index, second part as onset index
  localparam logic [4:0] CP_FIRST [CPAIR_COUNT] = '{
    5'd1, 5'd4, 5'd4, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd17
  };
  localparam logic [4:0] CP_SECOND [CPAIR_COUNT] = '{
    5'd9, 5'd12, 5'd18, 5'd0, 5'd6, 5'd7, 5'd9, 5'd16, 5'd17, 5'd18, 5'd9
  };

  typedef struct packed {
    logic        hit;
    logic [4:0]  idx;
  } idx_hit_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] code;
  } code_hit_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  first;
    logic [4:0]  second;
  } split_t;

  typedef struct packed {
    logic        onset_valid;
    logic [4:0]  onset_index;
    logic        vowel_valid;
    logic [4:0]  vowel_index;
    logic        coda_valid;
    logic [4:0]  coda_index;
    logic [15:0] raw_vowel_code;
    logic [15:0] raw_coda_code;
  } syl_t;

  typedef struct packed {
    logic        char_valid;
    logic [15:0] char_code;
    logic        last;
    logic        preedit_valid;
    logic [15:0] preedit_code;
    logic        composer_empty;
    logic        undo_done;
  } res_t;

  typedef struct packed {
    logic [1:0]  cnt;
    res_t        r0;
    res_t        r1;
  } res_pair_t;

  function automatic idx_hit_t onset_of(input logic [15:0] c);
    idx_hit_t r;
    r = '0;
    for (int i = 0; i < ONSET_COUNT; i++) begin
      if (ONSET_TAB[i] == c) begin
        r.hit = 1'b1;
        r.idx = 5'(i);
      end
    end
    return r;
  endfunction

  function automatic idx_hit_t coda_of(input logic [15:0] c);
    idx_hit_t r;
    r = '0;
    for (int i = 1; i < CODA_COUNT; i++) begin
      if (CODA_TAB[i] == c) begin
        r.hit = 1'b1;
        r.idx = 5'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] vowel_idx(input logic [15:0] c);
    logic [15:0] d;
    d = c - VOWEL_FIRST;
    return d[4:0];
  endfunction

  function automatic idx_hit_t vowel_of(input logic [15:0] c);
    idx_hit_t r;
    r.hit = (c >= VOWEL_FIRST) && (c <= VOWEL_LAST);
    r.idx = r.hit ? vowel_idx(c) : 5'd0;
    return r;
  endfunction

  function automatic logic [15:0] onset_letter(input logic [4:0] idx);
    return (idx < 5'(ONSET_COUNT)) ? ONSET_TAB[idx] : 16'h0000;
  endfunction

  function automatic logic [15:0] coda_code(input logic [4:0] idx);
    return (idx < 5'(CODA_COUNT)) ? CODA_TAB[idx] : 16'h0000;
  endfunction

  function automatic logic [15:0] composed(input logic [4:0] oi, input logic [4:0] vi,
                                           input logic [4:0] cd);
    return (16'(oi) * VOWEL_MUL + 16'(vi)) * CODA_MUL + 16'(cd) + BASE_CODE;
  endfunction

  function automatic code_hit_t vowel_join(input logic [15:0] rv, input logic [15:0] c);
    code_hit_t r;
    r = '0;
    for (int i = 0; i < VPAIR_COUNT; i++) begin
      if (VP_A[i] == rv && VP_B[i] == c) begin
        r.hit  = 1'b1;
        r.code = VP_RES[i];
      end
    end
    return r;
  endfunction

  function automatic code_hit_t vowel_unjoin(input logic [15:0] rv);
    code_hit_t r;
    r = '0;
    for (int i = 0; i < VPAIR_COUNT; i++) begin
      if (VP_RES[i] == rv) begin
        r.hit  = 1'b1;
        r.code = VP_A[i];
      end
    end
    return r;
  endfunction

  function automatic idx_hit_t coda_join(input logic [15:0] rc, input logic [15:0] c);
    idx_hit_t r;
    r = '0;
    for (int i = 0; i < CPAIR_COUNT; i++) begin
      if (CP_A[i] == rc && CP_B[i] == c) begin
        r.hit = 1'b1;
        r.idx = CP_RES[i];
      end
    end
    return r;
  endfunction

  function automatic split_t split_coda(input logic [4:0] idx);
    split_t r;
    r = '0;
    for (int i = 0; i < CPAIR_COUNT; i++) begin
      if (CP_RES[i] == idx) begin
        r.hit    = 1'b1;
        r.first  = CP_FIRST[i];
        r.second = CP_SECOND[i];
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/hangul_syllable_composer_top.sv */
// hangul_syllable_composer_top: request register, config registers, core and result queue
//
//   channel  ports                        payload
//   in       in_tvalid/tready/tdata/tuser  tdata jamo_code, tuser operation
//   out      out_tvalid/tready/tdata/...   tdata codes and status, tuser flags, tlast
//   cfg      cfg_psel/penable/pwrite/...   three 16-bit marker registers
//
// a request is registered, then decoded combinationally into one or two results
// steady rate one request per cycle while each gives one result and out_tready
// stays high; two-result requests leave one result at a time by the single out port
// rst_n clears the syllable state, the queue and the markers to defaults
// in_tready holds low only while the request register waits for queue space
module hangul_syllable_composer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // jamo_code
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // char_code, preedit_code, composer_empty, undo_done, pad
  output logic [1:0]  out_tuser,  // char_valid, preedit_valid
  output logic        out_tlast,  // last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hsc_pkg::*;

  logic        in_valid_r;
  logic [1:0]  in_op_r;
  logic [15:0] in_code_r;
  logic [15:0] wo_marker_r, wa_marker_r, e_marker_r;
  logic        room, fire, cfg_wr;
  res_pair_t   pair;
  res_t        res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wo_marker_r <= 16'd12434;
      wa_marker_r <= 16'd12399;
      e_marker_r  <= 16'd12408;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_WO:  wo_marker_r <= cfg_pwdata[15:0];
        REG_WA:  wa_marker_r <= cfg_pwdata[15:0];
        REG_E:   e_marker_r  <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_WO:  cfg_prdata = {16'h0000, wo_marker_r};
      REG_WA:  cfg_prdata = {16'h0000, wa_marker_r};
      REG_E:   cfg_prdata = {16'h0000, e_marker_r};
      default: cfg_prdata = 32'h0000_0000;
    endcase
  end

  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser;
      in_code_r <= in_tdata;
    end
  end

  hsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .op        (in_op_r),
    .code      (in_code_r),
    .wo_marker (wo_marker_r),
    .wa_marker (wa_marker_r),
    .e_marker  (e_marker_r),
    .pair      (pair)
  );

  hsc_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .pair      (pair),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {6'd0, res.undo_done, res.composer_empty, res.preedit_code,
                      res.char_code};
  assign out_tuser = {res.preedit_valid, res.char_valid};
  assign out_tlast = res.last;

endmodule

/* hw/rtl/hsc_core.sv */
// hsc_core: syllable state register and single-pass next-state and result logic
module hsc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [1:0]         op,
  input  logic [15:0]        code,
  input  logic [15:0]        wo_marker,
  input  logic [15:0]        wa_marker,
  input  logic [15:0]        e_marker,
  output hsc_pkg::res_pair_t pair
);
  import hsc_pkg::*;

  syl_t st_r, st_nxt, fe_st;
  logic fe_emit;
  idx_hit_t on_c, vw_c, cd_c, on_cc, cj;
  code_hit_t vj, vu;
  split_t sp;
  logic [15:0] comp_false, comp_true, comp_split, stat_code, mark;
  logic [15:0] em0, em1;
  logic [1:0]  em_cnt;
  logic        undone, mark_hit;
  res_t        stat;

  assign on_c  = onset_of(code);
  assign vw_c  = vowel_of(code);
  assign cd_c  = coda_of(code);
  assign vj    = vowel_join(st_r.raw_vowel_code, code);
  assign vu    = vowel_unjoin(st_r.raw_vowel_code);
  assign cj    = coda_join(st_r.raw_coda_code, code);
  assign sp    = split_coda(st_r.coda_index);
  assign on_cc = onset_of(coda_code(st_r.coda_index));

  assign comp_false = composed(st_r.onset_index, st_r.vowel_index, 5'd0);
  assign comp_true  = composed(st_r.onset_index, st_r.vowel_index,
                               st_r.coda_valid ? st_r.coda_index : 5'd0);
  assign comp_split = composed(st_r.onset_index, st_r.vowel_index, sp.first);

  // start over from the fed code, as on an empty composer
  always_comb begin
    fe_st   = '0;
    fe_emit = 1'b0;
    if (on_c.hit) begin
      fe_st.onset_valid = 1'b1;
      fe_st.onset_index = on_c.idx;
    end else if (vw_c.hit) begin
      fe_st.onset_valid    = 1'b1;
      fe_st.onset_index    = SILENT_ONSET;
      fe_st.vowel_valid    = 1'b1;
      fe_st.vowel_index    = vw_c.idx;
      fe_st.raw_vowel_code = code;
    end else begin
      fe_emit = 1'b1;
    end
  end

  // particle marker patterns
  always_comb begin
    mark_hit = 1'b0;
    mark     = 16'h0000;
    if (st_r.raw_vowel_code == VOWEL_O && code == VOWEL_O) begin
      mark_hit = 1'b1;
      mark     = wo_marker;
    end else if (st_r.raw_vowel_code == VOWEL_WA && code == VOWEL_A) begin
      mark_hit = 1'b1;
      mark     = wa_marker;
    end else if (st_r.raw_vowel_code == VOWEL_E && code == VOWEL_E) begin
      mark_hit = 1'b1;
      mark     = e_marker;
    end
  end

  always_comb begin
    st_nxt = st_r;
    em0    = 16'h0000;
    em1    = 16'h0000;
    em_cnt = 2'd0;
    undone = 1'b0;
    unique case (op)
      OP_FEED: begin
        if (!st_r.onset_valid) begin
          st_nxt = fe_st;
          em0    = code;
          em_cnt = fe_emit ? 2'd1 : 2'd0;
        end else if (!st_r.vowel_valid) begin
          if (vw_c.hit) begin
            st_nxt.vowel_valid    = 1'b1;
            st_nxt.vowel_index    = vw_c.idx;
            st_nxt.raw_vowel_code = code;
          end else begin
            st_nxt = fe_st;
            em0    = onset_letter(st_r.onset_index);
            em1    = code;
            em_cnt = fe_emit ? 2'd2 : 2'd1;
          end
        end else if (!st_r.coda_valid) begin
          if (vj.hit) begin
            st_nxt.raw_vowel_code = vj.code;
            st_nxt.vowel_index    = vowel_idx(vj.code);
          end else if (st_r.onset_index == SILENT_ONSET && mark_hit) begin
            st_nxt = '0;
            em0    = mark;
            em_cnt = 2'd1;
          end else if (cd_c.hit) begin
            st_nxt.coda_valid    = 1'b1;
            st_nxt.coda_index    = cd_c.idx;
            st_nxt.raw_coda_code = code;
          end else begin
            st_nxt = fe_st;
            em0    = comp_false;
            em1    = code;
            em_cnt = fe_emit ? 2'd2 : 2'd1;
          end
        end else if (vw_c.hit) begin
          // coda or its second part moves to the next onset
          st_nxt                = '0;
          st_nxt.onset_valid    = 1'b1;
          st_nxt.vowel_valid    = 1'b1;
          st_nxt.vowel_index    = vw_c.idx;
          st_nxt.raw_vowel_code = code;
          em_cnt                = 2'd1;
          if (sp.hit) begin
            st_nxt.onset_index = sp.second;
            em0                = comp_split;
          end else begin
            st_nxt.onset_index = on_cc.hit ? on_cc.idx : SILENT_ONSET;
            em0                = comp_false;
          end
        end else if (cj.hit) begin
          st_nxt.coda_index    = cj.idx;
          st_nxt.raw_coda_code = coda_code(cj.idx);
        end else begin
          st_nxt = fe_st;
          em0    = comp_true;
          em1    = code;
          em_cnt = fe_emit ? 2'd2 : 2'd1;
        end
      end
      OP_FLUSH: begin
        if (st_r.onset_valid) begin
          em0    = st_r.vowel_valid ? comp_true : onset_letter(st_r.onset_index);
          em_cnt = 2'd1;
          st_nxt = '0;
        end
      end
      OP_UNDO: begin
        if (st_r.coda_valid) begin
          undone = 1'b1;
          if (sp.hit) begin
            st_nxt.coda_index    = sp.first;
            st_nxt.raw_coda_code = coda_code(sp.first);
          end else begin
            st_nxt.coda_valid    = 1'b0;
            st_nxt.coda_index    = 5'd0;
            st_nxt.raw_coda_code = 16'h0000;
          end
        end else if (st_r.vowel_valid) begin
          undone = 1'b1;
          if (st_r.raw_vowel_code != 16'h0000 && vu.hit) begin
            st_nxt.raw_vowel_code = vu.code;
            st_nxt.vowel_index    = vowel_idx(vu.code);
          end else begin
            st_nxt.vowel_valid    = 1'b0;
            st_nxt.vowel_index    = 5'd0;
            st_nxt.raw_vowel_code = 16'h0000;
          end
        end else if (st_r.onset_valid) begin
          undone             = 1'b1;
          st_nxt.onset_valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // status from the state left behind
  assign stat_code = st_nxt.vowel_valid
                   ? composed(st_nxt.onset_index, st_nxt.vowel_index,
                              st_nxt.coda_valid ? st_nxt.coda_index : 5'd0)
                   : onset_letter(st_nxt.onset_index);

  always_comb begin
    stat                = '0;
    stat.last           = 1'b1;
    stat.preedit_valid  = st_nxt.onset_valid;
    stat.preedit_code   = st_nxt.onset_valid ? stat_code : 16'h0000;
    stat.composer_empty = !st_nxt.onset_valid;
    stat.undo_done      = undone;
  end

  always_comb begin
    pair = '0;
    if (em_cnt == 2'd2) begin
      pair.cnt           = 2'd2;
      pair.r0.char_valid = 1'b1;
      pair.r0.char_code  = em0;
      pair.r1            = stat;
      pair.r1.char_valid = 1'b1;
      pair.r1.char_code  = em1;
    end else begin
      pair.cnt           = 2'd1;
      pair.r0            = stat;
      pair.r0.char_valid = (em_cnt != 2'd0);
      pair.r0.char_code  = (em_cnt != 2'd0) ? em0 : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* hw/rtl/hsc_resq.sv */
// hsc_resq: four-entry result queue, up to two pushes and one pop per cycle
module hsc_resq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hsc_pkg::res_pair_t pair,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output hsc_pkg::res_t      out_res
);
  import hsc_pkg::*;

  res_t       q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + pair.cnt;
      cnt_nxt    = cnt_nxt + 3'(pair.cnt);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 2'd1;
      cnt_nxt    = cnt_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= pair.r0;
      if (pair.cnt == 2'd2) begin
        q_r[wr_ptr_r + 2'd1] <= pair.r1;
      end
    end
  end

endmodule

/* bench/hangul_syllable_composer_top_tb.sv */
// hangul_syllable_composer_top_tb: self-checking bench with a syllable predictor and stream drivers
`timescale 1ns / 1ps

module hangul_syllable_composer_top_tb;
  import hsc_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 150;

  localparam logic [15:0] PAIR_CONSONANTS [10] = '{
    16'h3131, 16'h3134, 16'h3139, 16'h3142, 16'h3145,
    16'h3148, 16'h314E, 16'h3141, 16'h314C, 16'h314D
  };
  localparam logic [15:0] JOIN_VOWELS [8] = '{
    16'h3157, 16'h315C, 16'h3161, 16'h314F, 16'h3163, 16'h3154, 16'h3150, 16'h3153
  };
  localparam logic [15:0] EDGE_CODES [3] = '{16'h3130, 16'h3164, 16'h0000};

  class composer_scoreboard;
    res_t        expected_q[$];
    logic [15:0] chars[$];
    int          mismatches;
    logic [15:0] wo_code, wa_code, e_code;
    logic        on_v, vw_v, cd_v;
    logic [4:0]  on_i, vw_i, cd_i;
    logic [15:0] raw_vw, raw_cd;

    function new();
      mismatches = 0;
      wo_code = 16'd12434;
      wa_code = 16'd12399;
      e_code  = 16'd12408;
      clear();
    endfunction

    function void set_marker(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_WO: wo_code = value;
        REG_WA: wa_code = value;
        REG_E:  e_code  = value;
        default: ;
      endcase
    endfunction

    function void clear();
      on_v = 1'b0; on_i = '0;
      vw_v = 1'b0; vw_i = '0;
      cd_v = 1'b0; cd_i = '0;
      raw_vw = '0; raw_cd = '0;
    endfunction

    function int find_onset(logic [15:0] c);
      for (int i = 0; i < ONSET_COUNT; i++) begin
        if (ONSET_TAB[i] == c) return i;
      end
      return -1;
    endfunction

    function int find_coda(logic [15:0] c);
      for (int i = 1; i < CODA_COUNT; i++) begin
        if (CODA_TAB[i] == c) return i;
      end
      return -1;
    endfunction

    function int vowel_pos(logic [15:0] c);
      if (c >= VOWEL_FIRST && c <= VOWEL_LAST) return int'(c) - int'(VOWEL_FIRST);
      return -1;
    endfunction

    function logic [15:0] onset_char();
      return (int'(on_i) < ONSET_COUNT) ? ONSET_TAB[on_i] : 16'h0000;
    endfunction

    function logic [15:0] syllable(bit with_coda);
      int total;
      total = (int'(on_i) * int'(VOWEL_MUL) + int'(vw_i)) * int'(CODA_MUL)
              + ((with_coda && cd_v) ? int'(cd_i) : 0) + int'(BASE_CODE);
      return total[15:0];
    endfunction

    // compound coda -> first part as coda index, second part as onset index
    function bit split_compound(logic [4:0] idx, output int head, output int tail);
      head = -1;
      tail = -1;
      for (int i = 0; i < CPAIR_COUNT; i++) begin
        if (CP_RES[i] == idx) begin
          head = find_coda(CP_A[i]);
          tail = find_onset(CP_B[i]);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void emit(logic [15:0] c);
      if (chars.size() < 2) chars.push_back(c);
    endfunction

    function void start_fresh(logic [15:0] c);
      int oi, vi;
      oi = find_onset(c);
      vi = vowel_pos(c);
      clear();
      if (oi >= 0) begin
        on_v = 1'b1; on_i = 5'(oi);
      end else if (vi >= 0) begin
        on_v = 1'b1; on_i = SILENT_ONSET;
        vw_v = 1'b1; vw_i = 5'(vi); raw_vw = c;
      end else begin
        emit(c);
      end
    endfunction

    function void begin_next(logic [4:0] onset, int vi, logic [15:0] c);
      clear();
      on_v = 1'b1; on_i = onset;
      vw_v = 1'b1; vw_i = 5'(vi); raw_vw = c;
    endfunction

    function void feed(logic [15:0] c);
      int vi, ci, head, tail, no;
      bit hit;
      logic [15:0] mark;
      vi = vowel_pos(c);
      if (!on_v) begin
        start_fresh(c);
        return;
      end
      if (!vw_v) begin
        if (vi >= 0) begin
          vw_v = 1'b1; vw_i = 5'(vi); raw_vw = c;
          return;
        end
        emit(onset_char());
        start_fresh(c);
        return;
      end
      if (!cd_v) begin
        for (int i = 0; i < VPAIR_COUNT; i++) begin
          if (VP_A[i] == raw_vw && VP_B[i] == c) begin
            raw_vw = VP_RES[i];
            vw_i = 5'(vowel_pos(raw_vw));
            return;
          end
        end
        if (on_i == SILENT_ONSET) begin
          hit = 1'b1;
          mark = '0;
          if (raw_vw == VOWEL_O && c == VOWEL_O) mark = wo_code;
          else if (raw_vw == VOWEL_WA && c == VOWEL_A) mark = wa_code;
          else if (raw_vw == VOWEL_E && c == VOWEL_E) mark = e_code;
          else hit = 1'b0;
          if (hit) begin
            clear();
            emit(mark);
            return;
          end
        end
        ci = find_coda(c);
        if (ci >= 0) begin
          cd_v = 1'b1; cd_i = 5'(ci); raw_cd = c;
          return;
        end
        emit(syllable(1'b0));
        start_fresh(c);
        return;
      end
      if (vi >= 0) begin
        if (split_compound(cd_i, head, tail) && head >= 0 && tail >= 0) begin
          cd_i = 5'(head);
          emit(syllable(1'b1));
          begin_next(5'(tail), vi, c);
          return;
        end
        no = find_onset((int'(cd_i) < CODA_COUNT) ? CODA_TAB[cd_i] : 16'h0000);
        emit(syllable(1'b0));
        begin_next((no >= 0) ? 5'(no) : SILENT_ONSET, vi, c);
        return;
      end
      for (int i = 0; i < CPAIR_COUNT; i++) begin
        if (CP_A[i] == raw_cd && CP_B[i] == c) begin
          cd_i = CP_RES[i];
          raw_cd = CODA_TAB[cd_i];
          return;
        end
      end
      emit(syllable(1'b1));
      start_fresh(c);
    endfunction

    function bit undo();
      int head, tail;
      if (cd_v) begin
        if (split_compound(cd_i, head, tail) && head >= 0) begin
          cd_i = 5'(head);
          raw_cd = CODA_TAB[cd_i];
        end else begin
          cd_v = 1'b0; cd_i = '0; raw_cd = '0;
        end
        return 1'b1;
      end
      if (vw_v) begin
        if (raw_vw != 16'h0000) begin
          for (int i = 0; i < VPAIR_COUNT; i++) begin
            if (VP_RES[i] == raw_vw) begin
              raw_vw = VP_A[i];
              vw_i = 5'(vowel_pos(raw_vw));
              return 1'b1;
            end
          end
        end
        vw_v = 1'b0; vw_i = '0; raw_vw = '0;
        return 1'b1;
      end
      if (on_v) begin
        on_v = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] code);
      bit   undone;
      int   n;
      res_t r;
      undone = 1'b0;
      chars.delete();
      case (op)
        OP_FEED: feed(code);
        OP_FLUSH: begin
          if (on_v) begin
            emit(vw_v ? syllable(1'b1) : onset_char());
            clear();
          end
        end
        OP_UNDO: undone = undo();
        default: ;
      endcase
      n = (chars.size() > 0) ? chars.size() : 1;
      for (int k = 0; k < n; k++) begin
        r = '0;
        if (k < chars.size()) begin
          r.char_valid = 1'b1;
          r.char_code  = chars[k];
        end
        if (k == n - 1) begin
          r.last = 1'b1;
          if (on_v) begin
            r.preedit_valid = 1'b1;
            r.preedit_code  = vw_v ? syllable(1'b1) : onset_char();
          end
          r.composer_empty = ~on_v;
          r.undo_done      = undone;
        end
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        mismatches++;
        $display("%0t: %s expected %h got %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, expected none got %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("char_valid", 16'(want.char_valid), 16'(got.char_valid));
      compare_field("char_code", want.char_code, got.char_code);
      compare_field("last", 16'(want.last), 16'(got.last));
      compare_field("preedit_valid", 16'(want.preedit_valid), 16'(got.preedit_valid));
      compare_field("preedit_code", want.preedit_code, got.preedit_code);
      compare_field("composer_empty", 16'(want.composer_empty), 16'(got.composer_empty));
      compare_field("undo_done", 16'(want.undo_done), 16'(got.undo_done));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // jamo_code
  logic [1:0]  in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // char_code, preedit_code, composer_empty, undo_done, pad
  logic [1:0]  out_tuser;  // char_valid, preedit_valid
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  composer_scoreboard sb;
  int cycle_count;
  int ready_mode;
  int ready_mode_left;

  hangul_syllable_composer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        sb.check_result('{char_valid: out_tuser[0], char_code: out_tdata[15:0],
                          last: out_tlast, preedit_valid: out_tuser[1],
                          preedit_code: out_tdata[31:16], composer_empty: out_tdata[32],
                          undo_done: out_tdata[33]});
      end
    end
  end

  // receiver stall pattern: always ready, coin flip, or mostly stalled
  always @(negedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      <= $urandom_range(2);
      ready_mode_left <= $urandom_range(200, 20);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(1));
      default: out_tready <= ($urandom_range(3) == 0);
    endcase
  end

  task automatic push_request(input logic [1:0] op, input logic [15:0] code);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tdata  <= 16'($urandom);
    in_tuser  <= 2'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drain();
    idle_gap(1);
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_marker(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_marker(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    logic [1:0]  op;
    logic [15:0] code;
    logic [15:0] marker;
    int sel, counted, burst_left, kind;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cycle_count = 0;
    ready_mode = 0;
    ready_mode_left = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, markers at reset values
    push_request(OP_UNUSED, 16'hFFFF);
    push_request(OP_UNDO, 16'h0000);
    push_request(OP_FLUSH, 16'h0000);
    push_request(OP_FEED, 16'h0000);
    push_request(OP_FEED, 16'hFFFF);
    push_request(OP_FEED, 16'h3131);
    push_request(OP_FEED, 16'h314F);
    push_request(OP_FEED, 16'h3131);
    push_request(OP_FEED, 16'h3145);
    push_request(OP_FEED, 16'h314F);  // compound coda splits into next onset
    push_request(OP_FEED, 16'h3134);
    push_request(OP_FEED, 16'h314E);
    push_request(OP_UNDO, 16'h0000);
    push_request(OP_UNDO, 16'h0000);
    push_request(OP_FEED, 16'h3139);
    push_request(OP_FEED, 16'h3153);  // single coda moves to next onset
    push_request(OP_FEED, 16'h0041);
    push_request(OP_FEED, 16'h3143);
    push_request(OP_FEED, 16'h3138);  // consonant after lone onset
    push_request(OP_FEED, 16'h3161);
    push_request(OP_FEED, 16'h3163);
    push_request(OP_UNDO, 16'h0000);
    push_request(OP_UNDO, 16'h0000);
    push_request(OP_UNDO, 16'h0000);
    push_request(OP_FEED, VOWEL_O);
    push_request(OP_FEED, VOWEL_O);
    push_request(OP_FEED, VOWEL_O);
    push_request(OP_FEED, VOWEL_A);
    push_request(OP_FEED, VOWEL_A);
    push_request(OP_FEED, VOWEL_E);
    push_request(OP_FEED, VOWEL_E);
    push_request(OP_FEED, 16'h3142);
    push_request(OP_FLUSH, 16'h0000);
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      if (p > 0) begin
        for (int r = 0; r < 3; r++) begin
          case (p)
            1: marker = 16'h0000;
            2: marker = 16'hFFFF;
            default: marker = 16'($urandom);
          endcase
          write_marker(2'(r), marker);
        end
      end
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (burst_left == 0) begin
          if ($urandom_range(39) == 0) wait_drain();
          else if ($urandom_range(2) != 0) idle_gap($urandom_range(8, 1));
          burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        sel = $urandom_range(99);
        op = OP_FEED;
        code = 16'($urandom);
        if (sel < 38) begin
          if ($urandom_range(1) == 1) code = PAIR_CONSONANTS[$urandom_range(9)];
          else code = 16'($urandom_range(16'h314E, 16'h3131));
        end else if (sel < 70) begin
          if ($urandom_range(1) == 1) code = JOIN_VOWELS[$urandom_range(7)];
          else code = 16'($urandom_range(VOWEL_LAST, VOWEL_FIRST));
        end else if (sel < 76) begin
          code = 16'($urandom);
        end else if (sel < 78) begin
          code = EDGE_CODES[$urandom_range(2)];
        end else if (sel < 86) begin
          op = OP_FLUSH;
        end else if (sel < 94) begin
          op = OP_UNDO;
        end else if (sel < 97) begin
          // particle pattern on a silent onset
          kind = $urandom_range(2);
          push_request(OP_FLUSH, 16'($urandom));
          push_request(OP_FEED, (kind == 2) ? VOWEL_E : VOWEL_O);
          if (kind == 1) push_request(OP_FEED, VOWEL_A);
          push_request(OP_FEED, (kind == 0) ? VOWEL_O : (kind == 1) ? VOWEL_A : VOWEL_E);
          counted += (kind == 1) ? 4 : 3;
          continue;
        end else begin
          op = OP_UNUSED;
        end
        push_request(op, code);
        if (op != OP_UNUSED) counted++;
      end
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* hangul_syllable_composer_top.f */
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_core.sv
hw/rtl/hsc_resq.sv
hw/rtl/hangul_syllable_composer_top.sv
bench/hangul_syllable_composer_top_tb.sv
